// File: hdl/wtt_pkg.sv
// Shared types, constants, the tile detection function and the coefficient function of the Winograd input transform.
`timescale 1ns / 1ps

package wtt_pkg;

    // Default plane side and supported range (4..16).
    localparam int PLANE_SIDE_DEF = 15;

    // Configuration map.
    localparam int             APB_ADDR_W          = 3;
    localparam logic [0:0]     REG_CHANNEL_COUNT   = 1'b0;
    localparam logic [8:0]     CHANNEL_COUNT_RESET = 9'd1;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 19;
    localparam int TILE_W   = 4;    // tile row or column number, up to 16 tiles per row
    localparam int OUT_TDATA_W = 40;

    // 4x4 block of samples, [row][column].
    typedef logic [3:0][3:0][SAMPLE_W-1:0] t_tile;

    // Tiles finished along one axis by a pixel.
    typedef struct packed {
        logic              hit;
        logic [TILE_W-1:0] first;   // first tile number along this axis
        logic              two;     // a second tile (first + 1) finishes too
        logic [1:0]        shift;   // window offset of the first tile origin
    } t_axis;

    // One queue entry: a window of four rows by four columns ending at the pixel.
    typedef struct packed {
        logic [7:0] plane;
        t_axis      ya;
        t_axis      xa;
        t_tile      win;
    } t_job;

    // Which tiles a row or column coordinate closes.
    function automatic t_axis axis_match(input logic [4:0] p, input logic [5:0] side);
        t_axis      a;
        logic [5:0] last;
        logic [4:0] half;
        last = side - 6'd1;
        half = p - 5'd2;
        a    = '0;
        if (!p[0] && p >= 5'd2) begin
            a.hit   = 1'b1;
            a.first = TILE_W'(half >> 1);
            a.two   = ({1'b0, p} == last);
            a.shift = 2'd0;
        end else if ({1'b0, p} == last) begin
            a.hit   = 1'b1;
            a.first = TILE_W'((side >> 1) - 6'd1);
            a.two   = 1'b0;
            a.shift = 2'd1;
        end
        return a;
    endfunction

    // One coefficient of B^T x B, idx = row * 4 + column.
    function automatic logic signed [COEFF_W-1:0] wino_coeff(input t_tile x,
                                                             input logic [3:0] idx);
        logic signed [COEFF_W-2:0] a [4];
        logic signed [COEFF_W-2:0] s0, s1, s2, s3;
        logic signed [COEFF_W-1:0] v;
        for (int j = 0; j < 4; j++) begin
            s0 = (COEFF_W-1)'(signed'(x[0][j]));
            s1 = (COEFF_W-1)'(signed'(x[1][j]));
            s2 = (COEFF_W-1)'(signed'(x[2][j]));
            s3 = (COEFF_W-1)'(signed'(x[3][j]));
            case (idx[3:2])
                2'd0:    a[j] = s0 - s2;
                2'd1:    a[j] = s1 + s2;
                2'd2:    a[j] = s2 - s1;
                default: a[j] = s1 - s3;
            endcase
        end
        case (idx[1:0])
            2'd0:    v = COEFF_W'(a[0]) - COEFF_W'(a[2]);
            2'd1:    v = COEFF_W'(a[1]) + COEFF_W'(a[2]);
            2'd2:    v = COEFF_W'(a[2]) - COEFF_W'(a[1]);
            default: v = COEFF_W'(a[1]) - COEFF_W'(a[3]);
        endcase
        return v;
    endfunction

endpackage

// File: hdl/winograd_input_tile_transform.sv
// Top level of the streaming Winograd F(2x2,3x3) input tile transform.
`timescale 1ns / 1ps

// Path: a pixel passes the front stage register, the job queue and the output register.
// Throughput: one pixel word per cycle in while the job queue has room; one coefficient
//   word per cycle out while i_m_tready is high, 16 per tile, so sustained pixel intake is
//   set by the single coefficient datapath in the back end.
// Reset (synchronous, active low): position, plane count, queue and output cleared,
//   channel_count to 1; the line store is not cleared and needs no clearing pass.
module winograd_input_tile_transform import wtt_pkg::*; #(
    parameter int PLANE_SIDE = PLANE_SIDE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Pixel input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [SAMPLE_W-1:0]    i_s_tdata,   // [15:0] pixel_value
    // Coefficient output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [7:0] plane_index, [13:8] tile_index, [17:14] coeff_index,
    // [36:18] coeff_value, [39:37] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast,   // last_of_run
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [8:0] r_channel_count;
    logic       w_cfg_write;

    // Queue handshake between front and back.
    logic       w_push, w_pop, w_q_valid, w_room;
    t_job       w_front_job, w_q_job;

    // Register 0 is channel_count; higher word addresses read as zero and drop writes.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNEL_COUNT_RESET;
        end else if (w_cfg_write && paddr[2] == REG_CHANNEL_COUNT) begin
            r_channel_count <= pwdata[8:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CHANNEL_COUNT) begin
            prdata = {23'd0, r_channel_count};
        end
    end

    // Front: store the pixel, build the 4x4 window, hand finished windows to the queue.
    wtt_front #(.PLANE_SIDE(PLANE_SIDE)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_tvalid),
        .i_pixel         (i_s_tdata),
        .o_ready         (o_s_tready),
        .i_room          (w_room),
        .i_channel_count (r_channel_count),
        .o_push          (w_push),
        .o_job           (w_front_job)
    );

    // Decouple pixel intake from coefficient output.
    wtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .o_room  (w_room)
    );

    // Back: expand each job into its tiles and coefficients.
    wtt_back #(.PLANE_SIDE(PLANE_SIDE)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_job    (w_q_job),
        .o_pop    (w_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

// File: hdl/wtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wtt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/wtt_front.sv
// Front end: line store, raster position, 4x4 sample window and tile detection.
`timescale 1ns / 1ps

module wtt_front import wtt_pkg::*; #(
    parameter int PLANE_SIDE = PLANE_SIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_pixel,
    output logic                o_ready,
    input  logic                i_room,
    input  logic [8:0]          i_channel_count,
    output logic                o_push,
    output t_job                o_job
);

    localparam int         AW   = $clog2(PLANE_SIDE);
    localparam logic [4:0] LAST = 5'(PLANE_SIDE - 1);
    localparam logic [5:0] SIDE = 6'(PLANE_SIDE);

    logic                r_s1_valid;
    logic [4:0]          r_row, r_col, n_row, n_col;
    logic [7:0]          r_plane, n_plane;
    logic [4:0]          r_s1_row, r_s1_col;
    logic [7:0]          r_s1_plane;
    logic [SAMPLE_W-1:0] r_s1_pixel;
    t_tile               r_win, w_win_next, w_win_mask;
    logic [3:0][SAMPLE_W-1:0] w_bank_q, w_col;
    logic [8:0]          w_next9;
    logic                w_accept;
    logic [AW-1:0]       w_addr;
    t_axis               w_ya, w_xa;

    assign o_ready  = i_room;
    assign w_accept = i_valid && i_room;
    assign w_addr   = r_col[AW-1:0];

    // Four row banks; the bank of row r holds row r, r-4, ...
    for (genvar b = 0; b < 4; b++) begin : g_bank
        wtt_ram #(.WIDTH(SAMPLE_W), .DEPTH(PLANE_SIDE)) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_accept && (r_row[1:0] == 2'(b))),
            .i_waddr (w_addr),
            .i_wdata (i_pixel),
            .i_raddr (w_addr),
            .o_rdata (w_bank_q[b])
        );
    end

    // Raster position and plane counter.
    always_comb begin
        n_col   = r_col + 5'd1;
        n_row   = r_row;
        n_plane = r_plane;
        w_next9 = {1'b0, r_plane} + 9'd1;
        if (r_col == LAST) begin
            n_col = '0;
            n_row = r_row + 5'd1;
            if (r_row == LAST) begin
                n_row   = '0;
                n_plane = (w_next9 >= i_channel_count || w_next9[8]) ? '0 : w_next9[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_plane    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_plane <= n_plane;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_s1_plane <= r_plane;
            r_s1_pixel <= i_pixel;
        end
        if (r_s1_valid) begin
            r_win <= w_win_next;
        end
    end

    // Column of rows r-3..r at the current column, then shift it into the window.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_col[k] = w_bank_q[2'(r_s1_row[1:0] + 2'(k + 1))];
        end
        w_col[3] = r_s1_pixel;
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
                w_win_next[k][j] = (j < 3) ? r_win[k][(j + 1) % 4] : w_col[k];
            end
        end
        // Zero window rows and columns that lie above or left of the plane.
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
                if (({1'b0, r_s1_row} + 6'(k)) >= 6'd3 &&
                    ({1'b0, r_s1_col} + 6'(j)) >= 6'd3) begin
                    w_win_mask[k][j] = w_win_next[k][j];
                end else begin
                    w_win_mask[k][j] = '0;
                end
            end
        end
    end

    assign w_ya = axis_match(r_s1_row, SIDE);
    assign w_xa = axis_match(r_s1_col, SIDE);

    assign o_push = r_s1_valid && w_ya.hit && w_xa.hit;

    always_comb begin
        o_job.plane = r_s1_plane;
        o_job.ya    = w_ya;
        o_job.xa    = w_xa;
        o_job.win   = w_win_mask;
    end

endmodule

// File: hdl/wtt_queue.sv
// Short job queue between the front end and the coefficient back end.
`timescale 1ns / 1ps

module wtt_queue import wtt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic o_room
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    // Leave one slot for the job already inside the front pipeline.
    assign o_room  = (r_count <= (PW+1)'(QUEUE_DEPTH - 2));

endmodule

// File: hdl/wtt_back.sv
// Back end: walk a job's tiles, one coefficient word per cycle unless stalled.
`timescale 1ns / 1ps

module wtt_back import wtt_pkg::*; #(
    parameter int PLANE_SIDE = PLANE_SIDE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_job                   i_job,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tlast
);

    localparam int TPR = (PLANE_SIDE + 1) / 2;

    logic                      r_sub_y, r_sub_x;
    logic [3:0]                r_coef;
    logic                      r_out_valid;
    logic [7:0]                r_out_plane;
    logic [5:0]                r_out_tile;
    logic [3:0]                r_out_coef;
    logic signed [COEFF_W-1:0] r_out_value;
    logic                      r_out_last;

    logic                      w_adv, w_step, w_ydone, w_xdone, w_tile_end, w_last;
    logic [1:0]                w_dy, w_dx;
    logic [TILE_W-1:0]         w_ty, w_tx;
    logic [9:0]                w_tile_idx;
    t_tile                     w_x;
    logic [2:0]                w_ri, w_ci;
    logic signed [COEFF_W-1:0] w_value;

    assign w_adv      = !r_out_valid || i_tready;
    assign w_step     = i_valid && w_adv;
    assign w_ydone    = !i_job.ya.two || r_sub_y;
    assign w_xdone    = !i_job.xa.two || r_sub_x;
    assign w_tile_end = (r_coef == 4'd15);
    assign w_last     = w_tile_end && w_xdone && w_ydone;
    assign o_pop      = w_step && w_last;

    // Second tile along an axis always sits two samples further into the window.
    assign w_dy = r_sub_y ? 2'd2 : i_job.ya.shift;
    assign w_dx = r_sub_x ? 2'd2 : i_job.xa.shift;
    assign w_ty = i_job.ya.first + TILE_W'(r_sub_y);
    assign w_tx = i_job.xa.first + TILE_W'(r_sub_x);
    assign w_tile_idx = 10'(w_ty) * 10'(TPR) + 10'(w_tx);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_ri = 3'(i) + {1'b0, w_dy};
                w_ci = 3'(j) + {1'b0, w_dx};
                if (w_ri <= 3'd3 && w_ci <= 3'd3) begin
                    w_x[i][j] = i_job.win[w_ri[1:0]][w_ci[1:0]];
                end else begin
                    w_x[i][j] = '0;
                end
            end
        end
    end

    assign w_value = wino_coeff(w_x, r_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_y     <= 1'b0;
            r_sub_x     <= 1'b0;
            r_coef      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= i_valid;
            end
            if (w_step) begin
                r_coef <= r_coef + 4'd1;
                if (w_tile_end) begin
                    if (w_xdone) begin
                        r_sub_x <= 1'b0;
                        r_sub_y <= w_ydone ? 1'b0 : 1'b1;
                    end else begin
                        r_sub_x <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_plane <= i_job.plane;
            r_out_tile  <= w_tile_idx[5:0];
            r_out_coef  <= r_coef;
            r_out_value <= w_value;
            r_out_last  <= w_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {3'b000, r_out_value, r_out_coef, r_out_tile, r_out_plane};
    assign o_tlast  = r_out_last;

endmodule
